[rtl/shpt_pkg.sv]
// Shared types and constants of the spread histogram peak tracker.
`default_nettype none

package shpt_pkg;

  // Field and datapath widths
  localparam int DATA_W      = 32;
  localparam int BC_W        = 11;
  localparam int RAD_W       = 3;
  localparam int STEP_W      = 4;
  localparam int WT_W        = 17;
  localparam int POS_W       = 35;
  localparam int DIV_W       = 34;
  localparam int DIV_CNT_W   = 6;
  localparam int NP_W        = DATA_W + WT_W;
  localparam int OUT_BIN_W   = 10;
  localparam int OUT_TDATA_W = 112;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BIN_W - 3 * DATA_W;
  localparam int CFG_IDX_W   = 3;

  // Build-time defaults
  localparam int NUM_BINS_DEF   = 1024;
  localparam int MAX_RADIUS_DEF = 7;

  // Input kind codes
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  // Register reset values
  localparam logic [BC_W-1:0]   BIN_COUNT_RST = 11'd1024;
  localparam logic [DATA_W-1:0] RANGE_MIN_RST = 32'h0000_0000;
  localparam logic [DATA_W-1:0] BIN_SCALE_RST = 32'h0400_0000;
  localparam logic [DATA_W-1:0] BIN_WIDTH_RST = 32'h0000_0040;
  localparam logic [RAD_W-1:0]  RADIUS_RST    = 3'd0;
  localparam logic [WT_W-1:0]   INV_WEIGHT_RST = 17'h1_0000;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIN_COUNT  = 3'd0,
    REG_RANGE_MIN  = 3'd1,
    REG_BIN_SCALE  = 3'd2,
    REG_BIN_WIDTH  = 3'd3,
    REG_WRAP_MODE  = 3'd4,
    REG_RADIUS     = 3'd5,
    REG_INV_WEIGHT = 3'd6
  } cfg_reg_t;

  // Spread weight round(65536 / (|d|+1)) by distance |d|, halves rounding up
  localparam logic [WT_W-1:0] SPREAD_WEIGHT [8] = '{
    17'd65536, 17'd32768, 17'd21845, 17'd16384,
    17'd13107, 17'd10923, 17'd9362,  17'd8192
  };

endpackage

`default_nettype wire

[rtl/spread_histogram_peak_tracker.sv]
// Weighted histogram with neighbor spread and running peak, top level.
//
// Channels: in_* takes items (tuser = kind, 0 adds the sample in tdata, 1 clears
// all bins and the peak). out_* returns one peak report per item. cfg_* writes
// one register per transfer and is always ready; write it only while idle.
// Bins live in one synchronous memory (registered read). Each sample walks 2R+1
// neighbor bins (R = active spread radius) one per cycle, read-modify-write,
// with the previous write forwarded when the same bin comes up again.
// An item holds in_tready low from its transfer until its report is loaded;
// in wrap mode a base bin outside 0..count-1 first passes through a bit-serial
// modulo unit. A clear item sweeps the memory one bin per cycle. The report is
// held in an output register, so the next item is taken while it waits; a
// stalled receiver only holds the block in its last step once the next report
// is ready. After reset the block clears the memory with in_tready low;
// configuration writes are taken during that pass.
`default_nettype none

module spread_histogram_peak_tracker #(
  parameter int NUM_BINS   = shpt_pkg::NUM_BINS_DEF,
  parameter int MAX_RADIUS = shpt_pkg::MAX_RADIUS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input stream
  input  wire logic                               in_tvalid,
  output      logic                               in_tready,
  input  wire logic [shpt_pkg::DATA_W-1:0]        in_tdata,   // [31:0] sample
  input  wire logic                               in_tuser,   // [0] kind
  // result stream
  output      logic                               out_tvalid,
  input  wire logic                               out_tready,
  // [9:0] max_bin, [41:10] max_weight, [73:42] max_center,
  // [105:74] max_normalized, [111:106] zero
  output      logic [shpt_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output      logic                               out_tuser,  // [0] has_max
  // configuration writes
  input  wire logic                               cfg_valid,
  output      logic                               cfg_ready,
  input  wire logic [shpt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [shpt_pkg::DATA_W-1:0]        cfg_data
);

  import shpt_pkg::*;

  localparam int IDX_W = $clog2(NUM_BINS);
  localparam int CNT_W = $clog2(NUM_BINS + 1);
  localparam int CP_W  = DATA_W + IDX_W + 1;
  localparam logic signed [CP_W+1:0] C_MAX = (CP_W+2)'(32'h7FFF_FFFF);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MAG, S_MUL, S_RND, S_OFS, S_SEL,
    S_DIV, S_DFIX, S_SPREAD, S_DRAIN, S_RES, S_FIN
  } state_t;

  // Control state
  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic               clr_reply_r, clr_reply_nxt;
  logic               w_v_r, w_v_nxt;
  logic               fwd_hit_r, fwd_hit_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [DATA_W-1:0]  peak_w_r, peak_w_nxt;
  logic [IDX_W-1:0]   peak_idx_r, peak_idx_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  // Configuration registers
  logic [BC_W-1:0]    bin_count_r, bin_count_nxt;
  logic [DATA_W-1:0]  range_min_r, range_min_nxt;
  logic [DATA_W-1:0]  bin_scale_r, bin_scale_nxt;
  logic [DATA_W-1:0]  bin_width_r, bin_width_nxt;
  logic               wrap_mode_r, wrap_mode_nxt;
  logic [RAD_W-1:0]   radius_r, radius_nxt;
  logic [WT_W-1:0]    inv_weight_r, inv_weight_nxt;

  // Datapath registers
  logic [CNT_W-1:0]          n_r, n_nxt;
  logic [RAD_W-1:0]          rad_r, rad_nxt;
  logic signed [DATA_W:0]    d_r, d_nxt;
  logic                      neg_r, neg_nxt;
  logic [DATA_W-1:0]         mag_r, mag_nxt;
  logic [2*DATA_W-1:0]       p_r, p_nxt;
  logic [DATA_W:0]           hi_r, hi_nxt;
  logic signed [POS_W-1:0]   v_r, v_nxt;
  logic signed [POS_W-1:0]   pos_r, pos_nxt;
  logic [DIV_W-1:0]          a_r, a_nxt;
  logic [CNT_W-1:0]          rem_r, rem_nxt;
  logic [IDX_W-1:0]          w_addr_r, w_addr_nxt;
  logic [WT_W-1:0]           w_wt_r, w_wt_nxt;
  logic [DATA_W-1:0]         fwd_data_r, fwd_data_nxt;
  logic [CP_W-1:0]           cprod_r, cprod_nxt;
  logic [NP_W-1:0]           nprod_r, nprod_nxt;
  logic [OUT_TDATA_W-1:0]    out_tdata_r, out_tdata_nxt;
  logic                      out_tuser_r, out_tuser_nxt;

  // Bin memory
  logic [DATA_W-1:0] bin_mem [NUM_BINS];
  logic [DATA_W-1:0] rd_data_r;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;

  // Combinational helpers
  logic signed [DATA_W:0]    d_neg;
  logic [2*DATA_W:0]         rnd_sum;
  logic signed [POS_W-1:0]   hi_s, x_s, v_neg;
  logic signed [POS_W-1:0]   n_s, pos_inc;
  logic [CNT_W:0]            div_t;
  logic [CNT_W-1:0]          rem_fix;
  logic [STEP_W-1:0]         rad4, dist4;
  logic                      iss_v, step_last;
  logic [DATA_W-1:0]         upd_base, upd_val;
  logic [DATA_W:0]           upd_sum;
  logic [31:0]               n_wide;
  logic [CP_W-1:0]           c_half;
  logic signed [CP_W+1:0]    c_sum;
  logic [DATA_W-1:0]         c_val;
  logic [NP_W:0]             n_sum;
  logic [DATA_W-1:0]         n_val;
  logic                      has_max;
  logic                      in_xfer;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign n_s       = $signed(POS_W'(n_r));
  assign mem_raddr = pos_r[IDX_W-1:0];

  // Update the bin of the write stage, saturating at the 32-bit maximum
  always_comb begin
    upd_base = fwd_hit_r ? fwd_data_r : rd_data_r;
    upd_sum  = {1'b0, upd_base} + (DATA_W+1)'(w_wt_r);
    upd_val  = upd_sum[DATA_W] ? '1 : upd_sum[DATA_W-1:0];
  end

  // Route the memory write port: clearing sweep or spread write-back
  always_comb begin
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = w_v_r;
      mem_waddr = w_addr_r;
      mem_wdata = upd_val;
    end
  end

  // Sequencer and datapath next values
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    clr_reply_nxt  = clr_reply_r;
    w_v_nxt        = 1'b0;
    fwd_hit_nxt    = 1'b0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    peak_w_nxt     = peak_w_r;
    peak_idx_nxt   = peak_idx_r;
    step_nxt       = step_r;
    div_cnt_nxt    = div_cnt_r;

    bin_count_nxt  = bin_count_r;
    range_min_nxt  = range_min_r;
    bin_scale_nxt  = bin_scale_r;
    bin_width_nxt  = bin_width_r;
    wrap_mode_nxt  = wrap_mode_r;
    radius_nxt     = radius_r;
    inv_weight_nxt = inv_weight_r;

    n_nxt         = n_r;
    rad_nxt       = rad_r;
    d_nxt         = d_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    p_nxt         = p_r;
    hi_nxt        = hi_r;
    v_nxt         = v_r;
    pos_nxt       = pos_r;
    a_nxt         = a_r;
    rem_nxt       = rem_r;
    w_addr_nxt    = w_addr_r;
    w_wt_nxt      = w_wt_r;
    fwd_data_nxt  = fwd_data_r;
    cprod_nxt     = cprod_r;
    nprod_nxt     = nprod_r;
    out_tdata_nxt = out_tdata_r;
    out_tuser_nxt = out_tuser_r;

    d_neg     = -d_r;
    rnd_sum   = {1'b0, p_r} + (neg_r ? (2*DATA_W+1)'(32'h7FFF_FFFF)
                                     : (2*DATA_W+1)'(32'h8000_0000));
    hi_s      = $signed(POS_W'(hi_r));
    x_s       = neg_r ? -hi_s : hi_s;
    v_neg     = -v_r;
    pos_inc   = pos_r + POS_W'(1);
    div_t     = {rem_r, a_r[DIV_W-1]};
    rem_fix   = (v_r[POS_W-1] && (rem_r != '0)) ? (n_r - rem_r) : rem_r;
    rad4      = {1'b0, rad_r};
    dist4     = (step_r >= rad4) ? (step_r - rad4) : (rad4 - step_r);
    step_last = (step_r == {rad_r, 1'b0});
    iss_v     = wrap_mode_r || (!pos_r[POS_W-1] && (pos_r < n_s));
    n_wide    = (bin_count_r == '0) ? 32'd1 :
                ((32'(bin_count_r) > 32'(NUM_BINS)) ? 32'(NUM_BINS) : 32'(bin_count_r));

    has_max = (peak_w_r != '0);
    c_half  = (cprod_r + CP_W'(1)) >> 1;
    c_sum   = $signed({2'b0, c_half}) + (CP_W+2)'($signed(range_min_r));
    c_val   = (c_sum > C_MAX) ? 32'h7FFF_FFFF : c_sum[DATA_W-1:0];
    n_sum   = {1'b0, nprod_r} + (NP_W+1)'(16'h8000);
    n_val   = (n_sum[NP_W:DATA_W+16] != '0) ? '1 : n_sum[DATA_W+15:16];

    // Take configuration writes
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_BIN_COUNT:  bin_count_nxt  = cfg_data[BC_W-1:0];
        REG_RANGE_MIN:  range_min_nxt  = cfg_data;
        REG_BIN_SCALE:  bin_scale_nxt  = cfg_data;
        REG_BIN_WIDTH:  bin_width_nxt  = cfg_data;
        REG_WRAP_MODE:  wrap_mode_nxt  = cfg_data[0];
        REG_RADIUS:     radius_nxt     = cfg_data[RAD_W-1:0];
        REG_INV_WEIGHT: inv_weight_nxt = cfg_data[WT_W-1:0];
        default: ;
      endcase
    end

    // Retire the write stage and track the first strict maximum
    if (w_v_r && (upd_val > peak_w_r)) begin
      peak_w_nxt   = upd_val;
      peak_idx_nxt = w_addr_r;
    end

    unique case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == IDX_W'(NUM_BINS - 1)) begin
          state_nxt = clr_reply_r ? S_RES : S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + IDX_W'(1);
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          n_nxt   = n_wide[CNT_W-1:0];
          rad_nxt = (32'(radius_r) < 32'(MAX_RADIUS)) ? radius_r : RAD_W'(MAX_RADIUS);
          d_nxt   = $signed({in_tdata[DATA_W-1], in_tdata})
                  - $signed({range_min_r[DATA_W-1], range_min_r});
          if (in_tuser == KIND_CLEAR) begin
            peak_w_nxt    = '0;
            peak_idx_nxt  = '0;
            clr_addr_nxt  = '0;
            clr_reply_nxt = 1'b1;
            state_nxt     = S_CLEAR;
          end else begin
            state_nxt = S_MAG;
          end
        end
      end
      S_MAG: begin
        neg_nxt   = d_r[DATA_W];
        mag_nxt   = d_r[DATA_W] ? d_neg[DATA_W-1:0] : d_r[DATA_W-1:0];
        state_nxt = S_MUL;
      end
      S_MUL: begin
        p_nxt     = mag_r * bin_scale_r;
        state_nxt = S_RND;
      end
      S_RND: begin
        // Round half up on the positive side; below zero halves go toward the ceiling
        hi_nxt    = rnd_sum[2*DATA_W:DATA_W];
        state_nxt = S_OFS;
      end
      S_OFS: begin
        v_nxt     = x_s - $signed(POS_W'(rad_r));
        state_nxt = S_SEL;
      end
      S_SEL: begin
        step_nxt = '0;
        if (!wrap_mode_r || (!v_r[POS_W-1] && (v_r < n_s))) begin
          pos_nxt   = v_r;
          state_nxt = S_SPREAD;
        end else begin
          a_nxt       = v_r[POS_W-1] ? v_neg[DIV_W-1:0] : v_r[DIV_W-1:0];
          rem_nxt     = '0;
          div_cnt_nxt = '0;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        // Restoring remainder, one dividend bit per cycle
        rem_nxt     = (div_t >= {1'b0, n_r}) ? CNT_W'(div_t - {1'b0, n_r})
                                             : div_t[CNT_W-1:0];
        a_nxt       = {a_r[DIV_W-2:0], 1'b0};
        div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        if (div_cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
          state_nxt = S_DFIX;
        end
      end
      S_DFIX: begin
        pos_nxt   = $signed(POS_W'(rem_fix));
        state_nxt = S_SPREAD;
      end
      S_SPREAD: begin
        // Issue one neighbor read; forward the write of the same bin
        w_v_nxt      = iss_v;
        w_addr_nxt   = pos_r[IDX_W-1:0];
        w_wt_nxt     = SPREAD_WEIGHT[dist4[RAD_W-1:0]];
        fwd_hit_nxt  = iss_v && w_v_r && (pos_r[IDX_W-1:0] == w_addr_r);
        fwd_data_nxt = upd_val;
        if (wrap_mode_r) begin
          pos_nxt = (pos_inc == n_s) ? '0 : pos_inc;
        end else begin
          pos_nxt = pos_inc;
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_RES;
      end
      S_RES: begin
        cprod_nxt = {peak_idx_r, 1'b1} * bin_width_r;
        nprod_nxt = peak_w_r * inv_weight_r;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // Load the report once the output register is free
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = has_max;
          out_tdata_nxt  = has_max ? {OUT_PAD_W'(0), n_val, c_val, peak_w_r,
                                      OUT_BIN_W'(peak_idx_r)} : '0;
          clr_reply_nxt  = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      clr_reply_r  <= 1'b0;
      w_v_r        <= 1'b0;
      fwd_hit_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
      peak_w_r     <= '0;
      peak_idx_r   <= '0;
      step_r       <= '0;
      div_cnt_r    <= '0;
      bin_count_r  <= BIN_COUNT_RST;
      range_min_r  <= RANGE_MIN_RST;
      bin_scale_r  <= BIN_SCALE_RST;
      bin_width_r  <= BIN_WIDTH_RST;
      wrap_mode_r  <= 1'b0;
      radius_r     <= RADIUS_RST;
      inv_weight_r <= INV_WEIGHT_RST;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      clr_reply_r  <= clr_reply_nxt;
      w_v_r        <= w_v_nxt;
      fwd_hit_r    <= fwd_hit_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      peak_w_r     <= peak_w_nxt;
      peak_idx_r   <= peak_idx_nxt;
      step_r       <= step_nxt;
      div_cnt_r    <= div_cnt_nxt;
      bin_count_r  <= bin_count_nxt;
      range_min_r  <= range_min_nxt;
      bin_scale_r  <= bin_scale_nxt;
      bin_width_r  <= bin_width_nxt;
      wrap_mode_r  <= wrap_mode_nxt;
      radius_r     <= radius_nxt;
      inv_weight_r <= inv_weight_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    rad_r       <= rad_nxt;
    d_r         <= d_nxt;
    neg_r       <= neg_nxt;
    mag_r       <= mag_nxt;
    p_r         <= p_nxt;
    hi_r        <= hi_nxt;
    v_r         <= v_nxt;
    pos_r       <= pos_nxt;
    a_r         <= a_nxt;
    rem_r       <= rem_nxt;
    w_addr_r    <= w_addr_nxt;
    w_wt_r      <= w_wt_nxt;
    fwd_data_r  <= fwd_data_nxt;
    cprod_r     <= cprod_nxt;
    nprod_r     <= nprod_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  // Bin memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= bin_mem[mem_raddr];
  end

  // Write-back happens only inside the spread walk
  a_wb_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    w_v_r |-> (state_r == S_SPREAD || state_r == S_DRAIN))
    else $error("bin write-back outside the spread walk");

  // An empty report carries all-zero data
  a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("empty report with nonzero data");

  // A zero peak always points at bin zero
  a_peak_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (peak_w_r == '0) |-> (peak_idx_r == '0))
    else $error("zero peak weight with nonzero peak index");

  // One item at a time: busy right after an input transfer
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while an item is in progress");

endmodule

`default_nettype wire
